// ----- rtl/core/fsmr_pkg.sv -----
// Shared constants, types and helpers for the flow steering map rebuild block.
package fsmr_pkg;

  localparam int MAX_THREADS = 64;
  localparam int IDX_W       = $clog2(MAX_THREADS);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);
  localparam int TC_W        = 7;
  localparam int FIELD_W     = 6;
  localparam int QDEPTH      = 2;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic CFG_STEER_EN  = 1'b0;
  localparam logic CFG_THREAD_CNT = 1'b1;

  // event codes
  localparam logic CMD_WAKE = 1'b0;
  localparam logic CMD_PARK = 1'b1;

  // one rebuild job: covered awake bits and the slot count
  typedef struct packed {
    logic [MAX_THREADS-1:0] bits;
    logic [CNT_W-1:0]       n;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } qstat_t;

  // lowest set bit; zero when the vector is empty
  function automatic logic [IDX_W-1:0] ffs(input logic [MAX_THREADS-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int j = MAX_THREADS - 1; j >= 0; j--) begin
      if (v[j]) r = IDX_W'(j);
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/flow_steering_map_rebuild.sv -----
// Top level: round-robin flow steering map rebuild.
// A rebuild event is queued, loaded, prepared, then its first entry is registered.
// The walker gives one entry per cycle; it takes a new job only when idle.
// The two-entry job queue sets busy: busy rises when two rebuilds are pending.
// Synchronous active-low reset: steering off, thread count 64, all threads parked.
// Results appear for one cycle on out_valid; the receiver cannot stall them.
module flow_steering_map_rebuild (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_cmd,
  input  logic [5:0] in_thread_index,
  input  logic       in_voluntary,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_index,
  input  logic [6:0] cfg_data,
  output logic       out_valid,
  output logic [5:0] out_entry_index,
  output logic [5:0] out_target_thread,
  output logic       out_last
);
  import fsmr_pkg::*;

  job_t   push_job;
  job_t   head;
  qstat_t stat;
  logic   push;
  logic   pop;
  logic   accept;

  assign busy      = stat.full;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  fsmr_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .accept          (accept),
    .in_cmd          (in_cmd),
    .in_thread_index (in_thread_index),
    .in_voluntary    (in_voluntary),
    .push            (push),
    .job             (push_job)
  );

  fsmr_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (push_job),
    .pop    (pop),
    .head   (head),
    .stat   (stat)
  );

  fsmr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .stat              (stat),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_entry_index   (out_entry_index),
    .out_target_thread (out_target_thread),
    .out_last          (out_last)
  );

endmodule

// ----- rtl/core/fsmr_front.sv -----
// Front end: config registers, awake bitmap, event classification and job push.
module fsmr_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data,
  input  logic                 accept,
  input  logic                 in_cmd,
  input  logic [5:0]           in_thread_index,
  input  logic                 in_voluntary,
  output logic                 push,
  output fsmr_pkg::job_t       job
);
  import fsmr_pkg::*;

  logic                   steer_en_r;
  logic [TC_W-1:0]        thread_count_r;
  logic [MAX_THREADS-1:0] awake_r;
  logic [MAX_THREADS-1:0] awake_nxt;
  logic [MAX_THREADS-1:0] covered;
  logic [CNT_W-1:0]       n_sat;
  logic                   take;

  assign take = accept && steer_en_r &&
                (TC_W'(in_thread_index) < TC_W'(MAX_THREADS));

  always_comb begin
    awake_nxt = awake_r;
    if (take) begin
      awake_nxt[in_thread_index[IDX_W-1:0]] = (in_cmd == CMD_WAKE);
    end
  end

  assign n_sat = (thread_count_r > TC_W'(MAX_THREADS)) ? CNT_W'(MAX_THREADS)
                                                      : CNT_W'(thread_count_r);

  always_comb begin
    for (int j = 0; j < MAX_THREADS; j++) begin
      covered[j] = (CNT_W'(j) < n_sat);
    end
  end

  // wake and voluntary park rebuild; involuntary park only clears the bit
  assign push     = take && ((in_cmd == CMD_WAKE) || in_voluntary);
  assign job.bits = awake_nxt & covered;
  assign job.n    = n_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steer_en_r     <= 1'b0;
      thread_count_r <= TC_W'(MAX_THREADS);
      awake_r        <= '0;
    end else begin
      awake_r <= awake_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_STEER_EN:   steer_en_r     <= cfg_data[0];
          CFG_THREAD_CNT: thread_count_r <= cfg_data;
          default:        ;
        endcase
      end
    end
  end

endmodule

// ----- rtl/core/fsmr_queue.sv -----
// Short job queue between the front end and the map walker.
module fsmr_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  fsmr_pkg::job_t  wr_job,
  input  logic            pop,
  output fsmr_pkg::job_t  head,
  output fsmr_pkg::qstat_t stat
);
  import fsmr_pkg::*;

  job_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign head       = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      count_r <= count_r + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

endmodule

// ----- rtl/core/fsmr_back.sv -----
// Map walker: one entry per covered slot; parked slots go round-robin to awake threads.
module fsmr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  fsmr_pkg::job_t   head,
  input  fsmr_pkg::qstat_t stat,
  output logic             pop,
  output logic             out_valid,
  output logic [5:0]       out_entry_index,
  output logic [5:0]       out_target_thread,
  output logic             out_last
);
  import fsmr_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_PREP, ST_WALK} state_t;

  state_t                 state_r;
  logic [MAX_THREADS-1:0] bits_r;
  logic [CNT_W-1:0]       n_r;
  logic [IDX_W-1:0]       slot_r;
  logic [IDX_W-1:0]       rr_r;
  logic                   valid_r;
  logic [5:0]             entry_r;
  logic [5:0]             target_r;
  logic                   last_r;

  logic [MAX_THREADS-1:0] above;
  logic [IDX_W-1:0]       rr_nxt;
  logic                   is_last;
  logic                   slot_awake;

  assign pop = (state_r == ST_IDLE) && !stat.empty;

  // next awake thread after rr, wrapping to the lowest
  always_comb begin
    for (int j = 0; j < MAX_THREADS; j++) begin
      above[j] = bits_r[j] && (IDX_W'(j) > rr_r);
    end
    rr_nxt = (|above) ? ffs(above) : ffs(bits_r);
  end

  assign is_last    = ((CNT_W'(slot_r) + 1'b1) == n_r);
  assign slot_awake = bits_r[slot_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (!stat.empty) begin
            bits_r  <= head.bits;
            n_r     <= head.n;
            state_r <= ST_PREP;
          end
        end
        ST_PREP: begin
          rr_r   <= ffs(bits_r);
          slot_r <= '0;
          state_r <= (bits_r == '0) ? ST_IDLE : ST_WALK;
        end
        ST_WALK: begin
          valid_r  <= 1'b1;
          entry_r  <= 6'(slot_r);
          target_r <= slot_awake ? 6'(slot_r) : 6'(rr_r);
          last_r   <= is_last;
          if (!slot_awake) rr_r <= rr_nxt;
          slot_r <= slot_r + 1'b1;
          if (is_last) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid         = valid_r;
  assign out_entry_index   = entry_r;
  assign out_target_thread = target_r;
  assign out_last          = last_r;

`ifndef SYNTH
  a_target_awake: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> bits_r[target_r[IDX_W-1:0]])
    else $error("steering target is not an awake thread");

  a_entries_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !last_r |=> valid_r && (entry_r == $past(entry_r) + 6'd1))
    else $error("map entries not consecutive");

  a_last_ends_map: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && last_r |=> !valid_r)
    else $error("entry emitted after final map entry");
`endif

endmodule
